// ----- rtl/psi_pkg.sv -----
// ----------------------------------------------------------------------------
// Priority stack package
// Shared constants, operation codes and fault codes of the priority stack.
// ----------------------------------------------------------------------------
`default_nettype none

package psi_pkg;

   // Default sizes of the stack and of its entries.
   localparam int DEPTH_DEF      = 16;
   localparam int ELEM_WIDTH_DEF = 32;
   localparam int PRIO_WIDTH_DEF = 8;

   // Operation codes carried by the func field. The fourth code acts as a peek.
   typedef enum logic [1:0] {
      FUNC_PUSH = 2'd0,
      FUNC_POP  = 2'd1,
      FUNC_PEEK = 2'd2
   } func_type;

   // Fault codes reported with every result word.
   typedef enum logic [1:0] {
      FAULT_NONE      = 2'd0,
      FAULT_POP_EMPTY = 2'd1,
      FAULT_PUSH_FULL = 2'd2
   } fault_type;

endpackage : psi_pkg

`default_nettype wire

// ----- rtl/psi_if.sv -----
// ----------------------------------------------------------------------------
// Priority stack channels
// Valid/ready channels for operation words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

// Operation channel: one word per push, pop or peek.
interface psi_req_if
   import psi_pkg::*;
#(
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
   parameter int PRIO_WIDTH = PRIO_WIDTH_DEF
);
   logic                  valid;
   logic                  ready;
   logic [1:0]            func;
   logic [ELEM_WIDTH-1:0] elem_in;
   logic [PRIO_WIDTH-1:0] prio_in;

   modport source (output valid, func, elem_in, prio_in, input ready);
   modport sink   (input valid, func, elem_in, prio_in, output ready);
endinterface : psi_req_if

// Result channel: one word per operation.
interface psi_rsp_if
   import psi_pkg::*;
#(
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
   parameter int PRIO_WIDTH = PRIO_WIDTH_DEF,
   parameter int CNT_WIDTH  = $clog2(DEPTH_DEF + 1)
);
   logic                  valid;
   logic                  ready;
   logic [ELEM_WIDTH-1:0] top_elem;
   logic [PRIO_WIDTH-1:0] top_prio;
   logic [CNT_WIDTH-1:0]  count;
   logic                  is_empty;
   logic [1:0]            fault;

   modport source (output valid, top_elem, top_prio, count, is_empty, fault, input ready);
   modport sink   (input valid, top_elem, top_prio, count, is_empty, fault, output ready);
endinterface : psi_rsp_if

`default_nettype wire

// ----- rtl/priority_stack_sorted_insert_core.sv -----
// ----------------------------------------------------------------------------
// Priority stack core
// Bounded priority stack kept as a sorted list in an entry memory.
// ----------------------------------------------------------------------------
// Usage: operation words (push, pop, peek) arrive on req_chan; every word
// gives exactly one result word on rsp_chan with the top element, its
// priority, the entry count, an empty flag and a fault code. Equal
// priorities leave in LIFO order. A pop of an empty stack and a push to a
// full stack change nothing and are flagged in the fault code.
// Entries sit in memory from the bottom (index 0) to the top (count - 1);
// the top entry is also held in a register for peeks and push compares.
// Path to the result word: a peek, a faulted operation, a pop that empties
// the stack or a push that lands on top goes straight to the result stage;
// a pop that leaves the stack non-empty first reads the new top back from
// memory; a push that moves entries up walks the memory one entry per cycle
// through its single read port, and the walk ends with the write of the new
// word. One operation is in flight at a time and req_chan.ready is high only
// while the core is idle, so a new word is not taken before the result of
// the last one is presented.
// Reset empties the stack; no memory clearing is needed. When the result
// receiver stalls, the finished word waits in the output register while
// the next operation is taken in; that operation holds before its own
// result until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_stack_sorted_insert_core
   import psi_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
   parameter int PRIO_WIDTH = PRIO_WIDTH_DEF,
   parameter int CNT_WIDTH  = $clog2(DEPTH + 1)
) (
   input wire logic  clock,
   input wire logic  reset,
   psi_req_if.sink   req_chan,
   psi_rsp_if.source rsp_chan
);

   localparam int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WORD_WIDTH = ELEM_WIDTH + PRIO_WIDTH;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PUT,
      ST_POP,
      ST_EMIT
   } state_type;

   // Control registers.
   state_type             state_ff, state_in;
   logic [CNT_WIDTH-1:0]  fill_ff, fill_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Datapath registers.
   logic [ADDR_WIDTH-1:0] idx_ff, idx_in;
   logic [ELEM_WIDTH-1:0] top_elem_ff, top_elem_in;
   logic [PRIO_WIDTH-1:0] top_prio_ff, top_prio_in;
   logic [ELEM_WIDTH-1:0] new_elem_ff, new_elem_in;
   logic [PRIO_WIDTH-1:0] new_prio_ff, new_prio_in;
   fault_type             fault_ff, fault_in;
   logic [ELEM_WIDTH-1:0] rsp_elem_ff, rsp_elem_in;
   logic [PRIO_WIDTH-1:0] rsp_prio_ff, rsp_prio_in;
   logic [CNT_WIDTH-1:0]  rsp_count_ff, rsp_count_in;
   logic                  rsp_empty_ff, rsp_empty_in;
   fault_type             rsp_fault_ff, rsp_fault_in;

   // Memory ports.
   logic                  wr_en;
   logic [ADDR_WIDTH-1:0] wr_addr;
   logic [WORD_WIDTH-1:0] wr_data;
   logic [ADDR_WIDTH-1:0] rd_addr;
   logic [WORD_WIDTH-1:0] rd_data;
   logic [ELEM_WIDTH-1:0] rd_elem;
   logic [PRIO_WIDTH-1:0] rd_prio;

   logic [CNT_WIDTH-1:0]  fill_dec1;
   logic [CNT_WIDTH-1:0]  fill_dec2;
   logic                  req_fire;
   logic                  rsp_free;

   assign fill_dec1 = fill_ff - CNT_WIDTH'(1);
   assign fill_dec2 = fill_ff - CNT_WIDTH'(2);
   assign rd_elem   = rd_data[ELEM_WIDTH-1:0];
   assign rd_prio   = rd_data[WORD_WIDTH-1:ELEM_WIDTH];
   assign req_fire  = req_chan.valid && (state_ff == ST_IDLE);
   assign rsp_free  = !rsp_valid_ff || rsp_chan.ready;

   psi_ram #(
      .DEPTH      (DEPTH),
      .WIDTH      (WORD_WIDTH),
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Sequencer: insertion walk, pop refill and result hand-off.
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      top_elem_in  = top_elem_ff;
      top_prio_in  = top_prio_ff;
      new_elem_in  = new_elem_ff;
      new_prio_in  = new_prio_ff;
      fault_in     = fault_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_elem_in  = rsp_elem_ff;
      rsp_prio_in  = rsp_prio_ff;
      rsp_count_in = rsp_count_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_fault_in = rsp_fault_ff;
      wr_en        = 1'b0;
      wr_addr      = fill_ff[ADDR_WIDTH-1:0];
      wr_data      = {req_chan.prio_in, req_chan.elem_in};
      rd_addr      = idx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               fault_in    = FAULT_NONE;
               new_elem_in = req_chan.elem_in;
               new_prio_in = req_chan.prio_in;
               state_in    = ST_EMIT;
               if (req_chan.func == FUNC_PUSH) begin
                  if (fill_ff == CNT_WIDTH'(DEPTH)) begin
                     fault_in = FAULT_PUSH_FULL;
                  end else if (fill_ff == '0 || req_chan.prio_in >= top_prio_ff) begin
                     // The new word becomes the top: append it.
                     wr_en       = 1'b1;
                     top_elem_in = req_chan.elem_in;
                     top_prio_in = req_chan.prio_in;
                     fill_in     = fill_ff + CNT_WIDTH'(1);
                  end else begin
                     // Walk down from the top, moving higher entries up.
                     rd_addr  = fill_dec1[ADDR_WIDTH-1:0];
                     idx_in   = fill_dec1[ADDR_WIDTH-1:0];
                     fill_in  = fill_ff + CNT_WIDTH'(1);
                     state_in = ST_SCAN;
                  end
               end else if (req_chan.func == FUNC_POP) begin
                  if (fill_ff == '0) begin
                     fault_in = FAULT_POP_EMPTY;
                  end else begin
                     fill_in = fill_dec1;
                     if (fill_ff > CNT_WIDTH'(1)) begin
                        rd_addr  = fill_dec2[ADDR_WIDTH-1:0];
                        state_in = ST_POP;
                     end
                  end
               end
            end
         end

         ST_SCAN: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff + ADDR_WIDTH'(1);
            if (rd_prio > new_prio_ff) begin
               wr_data = rd_data;
               if (idx_ff == '0) begin
                  state_in = ST_PUT;
               end else begin
                  rd_addr = idx_ff - ADDR_WIDTH'(1);
                  idx_in  = idx_ff - ADDR_WIDTH'(1);
               end
            end else begin
               wr_data  = {new_prio_ff, new_elem_ff};
               state_in = ST_EMIT;
            end
         end

         ST_PUT: begin
            // Lowest priority so far: the new word goes to the bottom.
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = {new_prio_ff, new_elem_ff};
            state_in = ST_EMIT;
         end

         ST_POP: begin
            top_elem_in = rd_elem;
            top_prio_in = rd_prio;
            state_in    = ST_EMIT;
         end

         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = fill_ff;
               rsp_empty_in = (fill_ff == '0);
               rsp_fault_in = fault_ff;
               rsp_elem_in  = (fill_ff == '0) ? '0 : top_elem_ff;
               rsp_prio_in  = (fill_ff == '0) ? '0 : top_prio_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff       <= idx_in;
      top_elem_ff  <= top_elem_in;
      top_prio_ff  <= top_prio_in;
      new_elem_ff  <= new_elem_in;
      new_prio_ff  <= new_prio_in;
      fault_ff     <= fault_in;
      rsp_elem_ff  <= rsp_elem_in;
      rsp_prio_ff  <= rsp_prio_in;
      rsp_count_ff <= rsp_count_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_fault_ff <= rsp_fault_in;
   end

   // Channel outputs.
   assign req_chan.ready    = (state_ff == ST_IDLE);
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.top_elem = rsp_elem_ff;
   assign rsp_chan.top_prio = rsp_prio_ff;
   assign rsp_chan.count    = rsp_count_ff;
   assign rsp_chan.is_empty = rsp_empty_ff;
   assign rsp_chan.fault    = rsp_fault_ff;

endmodule : priority_stack_sorted_insert_core

`default_nettype wire

// ----- rtl/psi_ram.sv -----
// ----------------------------------------------------------------------------
// Priority stack entry memory
// Simple dual-port memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module psi_ram
   import psi_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int WIDTH      = ELEM_WIDTH_DEF + PRIO_WIDTH_DEF,
   parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [ADDR_WIDTH-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]      wr_data,
   input  wire logic [ADDR_WIDTH-1:0] rd_addr,
   output      logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule : psi_ram

`default_nettype wire
